FILE: rtl/ofq_pkg.sv
package ofq_pkg;

    // Item kinds carried on tuser
    localparam logic [1:0] KIND_SAMPLE      = 2'd0;
    localparam logic [1:0] KIND_TICK        = 2'd1;
    localparam logic [1:0] KIND_CLEAR_FAULT = 2'd2;
    localparam logic [1:0] KIND_CLEAR_COUNT = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_CURRENT_LIMIT = 2'd0;
    localparam logic [1:0] CFG_NOISE_TIME    = 2'd1;
    localparam logic [1:0] CFG_REPEAT_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_WINDOW_TIME   = 2'd3;

    typedef struct packed {
        logic [14:0] current_limit;
        logic [15:0] noise_time_ms;
        logic [7:0]  repeat_limit;
        logic [15:0] window_time_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] current_ma;
        logic               paused;
    } t_item;

    typedef struct packed {
        logic       fault;
        logic [7:0] event_count;
        logic       noise_armed;
    } t_result;

endpackage

FILE: rtl/ofq_cfg_regs.sv
module ofq_cfg_regs
    import ofq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [1:0]  i_wr_index,
    input  logic [15:0] i_wr_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_CURRENT_LIMIT: r_cfg.current_limit  <= i_wr_data[14:0];
                CFG_NOISE_TIME:    r_cfg.noise_time_ms  <= i_wr_data;
                CFG_REPEAT_LIMIT:  r_cfg.repeat_limit   <= i_wr_data[7:0];
                CFG_WINDOW_TIME:   r_cfg.window_time_ms <= i_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/ofq_core.sv
module ofq_core
    import ofq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_en,
    input  t_item   i_item,
    output t_result o_next
);

    logic [15:0] r_noise_timer, n_noise_timer;
    logic        r_armed, n_armed;
    logic        r_noise_exp, n_noise_exp;
    logic [15:0] r_window_timer, n_window_timer;
    logic        r_window_exp, n_window_exp;
    logic [7:0]  r_events, n_events;
    logic        r_fault, n_fault;
    logic        w_high;

    // Sign-extend the current, zero-extend the limit, compare as signed values
    assign w_high = $signed({i_item.current_ma[15], i_item.current_ma})
                    >= $signed({2'b00, i_cfg.current_limit});

    always_comb begin
        n_noise_timer  = r_noise_timer;
        n_armed        = r_armed;
        n_noise_exp    = r_noise_exp;
        n_window_timer = r_window_timer;
        n_window_exp   = r_window_exp;
        n_events       = r_events;
        n_fault        = r_fault;
        case (i_item.kind)
            KIND_SAMPLE: begin
                if (!i_item.paused) begin
                    if (w_high) begin
                        if (!r_fault) begin
                            if (!r_armed) begin
                                // zero noise time never arms, only flags expiry
                                if (i_cfg.noise_time_ms == 16'd0) begin
                                    n_noise_exp   = 1'b1;
                                    n_noise_timer = 16'd0;
                                end else begin
                                    n_noise_timer = i_cfg.noise_time_ms;
                                    n_armed       = 1'b1;
                                    n_noise_exp   = 1'b0;
                                end
                            end else if (r_noise_exp) begin
                                n_noise_timer = 16'd0;
                                n_armed       = 1'b0;
                                n_events      = r_events + 8'd1;
                                if (n_events >= i_cfg.repeat_limit) begin
                                    n_fault        = 1'b1;
                                    n_events       = 8'd0;
                                    n_window_timer = 16'd0;
                                end else if (i_cfg.window_time_ms == 16'd0) begin
                                    n_window_exp   = 1'b1;
                                    n_window_timer = 16'd0;
                                end else begin
                                    n_window_timer = i_cfg.window_time_ms;
                                    n_window_exp   = 1'b0;
                                end
                            end
                        end
                    end else begin
                        n_noise_timer = 16'd0;
                        n_armed       = 1'b0;
                    end
                    // expired window drops the count
                    if (n_window_exp) begin
                        n_noise_timer  = 16'd0;
                        n_events       = 8'd0;
                        n_armed        = 1'b0;
                        n_window_timer = 16'd0;
                        n_window_exp   = 1'b0;
                    end
                end
            end
            KIND_TICK: begin
                if (r_noise_timer != 16'd0) begin
                    n_noise_timer = r_noise_timer - 16'd1;
                    n_noise_exp   = (r_noise_timer == 16'd1);
                end
                if (r_window_timer != 16'd0) begin
                    n_window_timer = r_window_timer - 16'd1;
                    n_window_exp   = (r_window_timer == 16'd1);
                end
            end
            KIND_CLEAR_FAULT: begin
                n_fault = 1'b0;
            end
            KIND_CLEAR_COUNT: begin
                n_noise_timer  = 16'd0;
                n_events       = 8'd0;
                n_armed        = 1'b0;
                n_window_timer = 16'd0;
                n_window_exp   = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_timer  <= 16'd0;
            r_armed        <= 1'b0;
            r_noise_exp    <= 1'b0;
            r_window_timer <= 16'd0;
            r_window_exp   <= 1'b0;
            r_events       <= 8'd0;
            r_fault        <= 1'b0;
        end else if (i_en) begin
            r_noise_timer  <= n_noise_timer;
            r_armed        <= n_armed;
            r_noise_exp    <= n_noise_exp;
            r_window_timer <= n_window_timer;
            r_window_exp   <= n_window_exp;
            r_events       <= n_events;
            r_fault        <= n_fault;
        end
    end

    assign o_next.fault       = n_fault;
    assign o_next.event_count = n_events;
    assign o_next.noise_armed = n_armed;

    a_timer_implies_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_noise_timer != 16'd0 |-> r_armed)
        else $error("noise timer running while disarmed");

    a_window_running_not_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window_timer != 16'd0 |-> !r_window_exp)
        else $error("window expired while its timer still runs");

    a_latch_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fault) |-> r_events == 8'd0)
        else $error("fault latched with events left in the count");

endmodule

FILE: rtl/overcurrent_fault_qualifier_top.sv
// Channel   Direction  Handshake                        Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata current, tuser kind+paused
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata fault, count, armed
// cfg       in         i_cfg_valid/o_cfg_ready          index, data
//
// One word in, one word out; a new word is taken every cycle when the output flows.
// The input register holds each word, then the state update writes the result register.
// The per-word state update is a single compare, decrement and flag pass.
// Reset is synchronous, active low, and clears the valid flags, the qualifier state and configuration to zero.
// A stalled output holds its word; the input register fills, then tready drops.
module overcurrent_fault_qualifier_top
    import ofq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] current_ma
    input  logic [2:0]  i_s_axis_tuser,   // [1:0] kind, [2] paused
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [0] fault, [8:1] event_count, [9] noise_armed
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    w_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result w_next;
    logic    w_out_free;
    logic    w_advance;
    logic    w_take_in;

    // Output register is empty or is taken this cycle
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_advance       = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign w_take_in       = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration is always accepted
    assign o_cfg_ready = 1'b1;

    ofq_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    ofq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_en    (w_advance),
        .i_item  (r_in),
        .o_next  (w_next)
    );

    // Input register: hold the word until the core consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take_in) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_in) begin
            r_in.kind       <= i_s_axis_tuser[1:0];
            r_in.paused     <= i_s_axis_tuser[2];
            r_in.current_ma <= i_s_axis_tdata;
        end
    end

    // Result register: advance on a processed word, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_next;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.noise_armed, r_out.event_count, r_out.fault};

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ofq_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;   // [15:0] current_ma
    logic [2:0]  i_s_axis_tuser;   // [1:0] kind, [2] paused
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;   // [0] fault, [8:1] event_count, [9] noise_armed
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    overcurrent_fault_qualifier_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Shadow of the configuration registers, updated as each write is accepted
    t_cfg        cfg_shadow;

    // Predicted qualifier state, all zero out of reset
    logic [15:0] noise_count;
    logic        noise_armed_q;
    logic        noise_done;
    logic [15:0] window_count;
    logic        window_done;
    logic [7:0]  event_tally;
    logic        fault_held;

    // Status words still owed by the block, oldest first
    t_result     expected_status[$];
    int          mismatch_count;

    // Idling controls for the sender and the receiver
    bit          source_idle_on;
    bit          sink_idle_on;
    int          sink_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs a handshake
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Stop both timers and drop the count; the noise expiry flag survives
    function automatic void drop_event_count();
        noise_count   = '0;
        event_tally   = '0;
        noise_armed_q = 1'b0;
        window_count  = '0;
        window_done   = 1'b0;
    endfunction

    // Advance the predicted state by one word and return the status it shows
    function automatic t_result qualify_item(input t_item it);
        t_result res;
        int      cur;
        int      lim;
        cur = $signed(it.current_ma);
        lim = int'(cfg_shadow.current_limit);
        case (it.kind)
            KIND_SAMPLE: begin
                if (!it.paused) begin
                    if (cur >= lim) begin
                        if (!fault_held) begin
                            if (!noise_armed_q) begin
                                // a zero noise time flags expiry but never arms
                                if (cfg_shadow.noise_time_ms == 16'd0) begin
                                    noise_done  = 1'b1;
                                    noise_count = '0;
                                end else begin
                                    noise_count   = cfg_shadow.noise_time_ms;
                                    noise_armed_q = 1'b1;
                                    noise_done    = 1'b0;
                                end
                            end else if (noise_done) begin
                                noise_count   = '0;
                                noise_armed_q = 1'b0;
                                event_tally   = event_tally + 8'd1;
                                if (event_tally >= cfg_shadow.repeat_limit) begin
                                    fault_held   = 1'b1;
                                    event_tally  = '0;
                                    window_count = '0;
                                end else if (cfg_shadow.window_time_ms == 16'd0) begin
                                    window_done  = 1'b1;
                                    window_count = '0;
                                end else begin
                                    window_count = cfg_shadow.window_time_ms;
                                    window_done  = 1'b0;
                                end
                            end
                        end
                    end else begin
                        noise_count   = '0;
                        noise_armed_q = 1'b0;
                    end
                    if (window_done) begin
                        drop_event_count();
                    end
                end
            end
            KIND_TICK: begin
                if (noise_count != 16'd0) begin
                    noise_count = noise_count - 16'd1;
                    noise_done  = (noise_count == 16'd0);
                end
                if (window_count != 16'd0) begin
                    window_count = window_count - 16'd1;
                    window_done  = (window_count == 16'd0);
                end
            end
            KIND_CLEAR_FAULT: begin
                fault_held = 1'b0;
            end
            default: begin
                drop_event_count();
            end
        endcase
        res.fault       = fault_held;
        res.event_count = event_tally;
        res.noise_armed = noise_armed_q;
        return res;
    endfunction

    // Offer one word, with an optional idle burst ahead of it, and log its status
    task automatic send_word(input logic [1:0] kind, input logic signed [15:0] cur,
                             input logic paused);
        t_item it;
        if (source_idle_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        it.kind       = kind;
        it.current_ma = cur;
        it.paused     = paused;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= cur;
        i_s_axis_tuser  <= {paused, kind};
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_status.push_back(qualify_item(it));
    endtask

    // Drop valid, wait for every owed status word, then let the pipeline settle
    task automatic wait_until_drained();
        i_s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_CURRENT_LIMIT: cfg_shadow.current_limit  = data[14:0];
            CFG_NOISE_TIME:    cfg_shadow.noise_time_ms  = data;
            CFG_REPEAT_LIMIT:  cfg_shadow.repeat_limit   = data[7:0];
            CFG_WINDOW_TIME:   cfg_shadow.window_time_ms = data;
            default: ;
        endcase
    endtask

    // Reprogram all four registers once the block has gone quiet
    task automatic configure(input int limit_ma, input int noise_ms, input int rep_limit,
                             input int window_ms);
        wait_until_drained();
        write_register(CFG_CURRENT_LIMIT, 16'(limit_ma));
        write_register(CFG_NOISE_TIME, 16'(noise_ms));
        write_register(CFG_REPEAT_LIMIT, 16'(rep_limit));
        write_register(CFG_WINDOW_TIME, 16'(window_ms));
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly samples and ticks, with currents clustered around the threshold
    function automatic t_item random_item();
        t_item it;
        int    pick;
        int    lim;
        int    offset;
        int    cur;
        lim  = int'(cfg_shadow.current_limit);
        pick = $urandom_range(0, 99);
        if (pick < 45)      it.kind = KIND_SAMPLE;
        else if (pick < 90) it.kind = KIND_TICK;
        else if (pick < 95) it.kind = KIND_CLEAR_FAULT;
        else                it.kind = KIND_CLEAR_COUNT;
        it.paused = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 3))
            0: cur = $signed($urandom_range(0, 65535)) - 32768;
            1, 2: begin
                offset = $urandom_range(0, 8);
                cur    = lim + offset - 4;
            end
            default: cur = lim + $urandom_range(0, 32767 - lim);
        endcase
        if (cur > 32767) cur = 32767;
        it.current_ma = 16'(cur);
        return it;
    endfunction

    task automatic send_random_words(input int count);
        t_item it;
        repeat (count) begin
            it = random_item();
            send_word(it.kind, it.current_ma, it.paused);
        end
    endtask

    // Registers at their reset values: zero limit and zero noise time
    task automatic test_reset_defaults();
        send_word(KIND_SAMPLE, 0, 1'b0);
        send_word(KIND_SAMPLE, 0, 1'b0);
        send_word(KIND_SAMPLE, -32768, 1'b0);
        send_word(KIND_TICK, 0, 1'b0);
        send_word(KIND_CLEAR_FAULT, 0, 1'b0);
        send_word(KIND_CLEAR_COUNT, 0, 1'b0);
        send_word(KIND_SAMPLE, 32767, 1'b1);
    endtask

    // Arm, qualify two events, latch the fault, then clear it
    task automatic test_noise_qualification();
        configure(1000, 2, 2, 3);
        send_word(KIND_SAMPLE, 1000, 1'b0);
        send_word(KIND_SAMPLE, 1500, 1'b0);
        send_word(KIND_TICK, 0, 1'b0);
        send_word(KIND_TICK, 0, 1'b0);
        send_word(KIND_SAMPLE, 999, 1'b1);
        send_word(KIND_SAMPLE, 32767, 1'b0);
        send_word(KIND_TICK, 0, 1'b0);
        send_word(KIND_SAMPLE, 1000, 1'b0);
        send_word(KIND_TICK, 0, 1'b0);
        send_word(KIND_TICK, 0, 1'b0);
        send_word(KIND_SAMPLE, 2000, 1'b0);
        // fault latched: high samples are ignored, low ones still disarm
        send_word(KIND_SAMPLE, 5000, 1'b0);
        send_word(KIND_SAMPLE, -1, 1'b0);
        send_word(KIND_CLEAR_FAULT, 0, 1'b0);
        send_word(KIND_CLEAR_COUNT, 0, 1'b0);
    endtask

    // Zero repeat limit latches at once; zero window clears on the same sample
    task automatic test_zero_limits();
        configure(0, 1, 0, 0);
        send_word(KIND_SAMPLE, 0, 1'b0);
        send_word(KIND_TICK, 0, 1'b0);
        send_word(KIND_SAMPLE, 5, 1'b0);
        send_word(KIND_CLEAR_FAULT, 0, 1'b0);
        configure(0, 1, 5, 0);
        send_word(KIND_SAMPLE, 0, 1'b0);
        send_word(KIND_TICK, 0, 1'b0);
        send_word(KIND_SAMPLE, 0, 1'b0);
    endtask

    // Random traffic over several settings, both extremes included
    task automatic test_random_phases();
        int limit_ma;
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0) begin
                configure(0, 0, 0, 0);
            end else if (phase == 1) begin
                configure(32767, 65535, 255, 65535);
            end else begin
                limit_ma = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                       : $urandom_range(0, 2000);
                configure(limit_ma, $urandom_range(1, 4), $urandom_range(0, 5),
                          $urandom_range(0, 8));
            end
            send_random_words(120);
        end
    endtask

    // Hold the receiver off long enough to fill the pipe and stall the input
    task automatic test_backpressure();
        configure(500, 1, 3, 4);
        sink_hold_cycles = 60;
        send_random_words(24);
        wait_until_drained();
    endtask

    // Closing stretch at full rate with no idling on either side
    task automatic test_full_rate();
        source_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
        configure($urandom_range(0, 1500), $urandom_range(1, 3), $urandom_range(1, 4),
                  $urandom_range(1, 6));
        send_random_words(150);
    endtask

    // Receiver: random stall bursts, plus a long hold when a test asks for one
    initial begin
        int burst;
        burst = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles = sink_hold_cycles - 1;
                i_m_axis_tready <= 1'b0;
            end else if (burst > 0) begin
                burst = burst - 1;
                i_m_axis_tready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 8) - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each accepted status word against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_status.size() == 0) begin
                $error("status word 0x%h arrived with nothing predicted", o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_status.pop_front();
                if (o_m_axis_tdata[0] !== want.fault) begin
                    $error("fault: expected %0d, got %0d", want.fault, o_m_axis_tdata[0]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[8:1] !== want.event_count) begin
                    $error("event_count: expected %0d, got %0d",
                           want.event_count, o_m_axis_tdata[8:1]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[9] !== want.noise_armed) begin
                    $error("noise_armed: expected %0d, got %0d",
                           want.noise_armed, o_m_axis_tdata[9]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_CURRENT_LIMIT;
        i_cfg_data      <= '0;
        cfg_shadow       = '0;
        noise_count      = '0;
        noise_armed_q    = 1'b0;
        noise_done       = 1'b0;
        window_count     = '0;
        window_done      = 1'b0;
        event_tally      = '0;
        fault_held       = 1'b0;
        mismatch_count   = 0;
        sink_hold_cycles = 0;
        source_idle_on   = 1'b1;
        sink_idle_on     = 1'b1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_noise_qualification();
        test_zero_limits();
        test_random_phases();
        test_backpressure();
        test_full_rate();

        wait_until_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_status.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/ofq_pkg.sv
rtl/ofq_cfg_regs.sv
rtl/ofq_core.sv
rtl/overcurrent_fault_qualifier_top.sv
bench/testbench.sv
